// ----- hdl/saos_pkg.sv -----
// Shared types, constants and the exponential weight table for the softmax core.
package saos_pkg;

    // Sizing
    localparam int VEC_DIM   = 128;
    localparam int KEY_SLOTS = 4096;
    localparam int EXP_DEPTH = 256;

    localparam int VEC_AW  = $clog2(VEC_DIM);
    localparam int KS_AW   = $clog2(KEY_SLOTS);
    localparam int EXP_AW  = $clog2(EXP_DEPTH + 1);
    localparam int SWEEP_N = (KEY_SLOTS > VEC_DIM) ? KEY_SLOTS : VEC_DIM;
    localparam int SW_W    = $clog2(SWEEP_N);

    // Datapath widths
    localparam int SUM_W   = 40;
    localparam int TOT_W   = 32;
    localparam int DOT_W   = 48;
    localparam int WGT_W   = 17;
    localparam int NUM_W   = 52;
    localparam int DIV_CW  = $clog2(NUM_W);

    // Request queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int QA_W    = $clog2(Q_DEPTH);

    localparam logic [15:0] SCALE_RST = 16'd5793;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_KEY   = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    // Classified request as it leaves the front
    typedef struct packed {
        t_op         op;
        logic [6:0]  dim;
        logic        dim_ok;
        logic [15:0] query_value;
        logic [12:0] key_index;
        logic        slot_ok;
        logic        from_buffer;
        logic        key_invalid;
        logic [15:0] key_element;
        logic [15:0] value_element;
        logic        last_dim;
    } t_req;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_KEY_MAC,
        S_SEEN,
        S_MUL,
        S_SCORE,
        S_DIFF,
        S_EXP,
        S_TOT,
        S_U_RD,
        S_U_MUL,
        S_U_WR,
        S_RD_WS,
        S_DIV,
        S_OUT
    } t_bstate;

    typedef logic [WGT_W-1:0] t_exp_tab [0:EXP_DEPTH];

    // exp(-16 i / EXP_DEPTH) in Q1.16, built at elaboration as 2^-(x log2 e)
    function automatic t_exp_tab build_exp_tab();
        t_exp_tab          tab;
        longint unsigned   x;
        longint unsigned   y;
        longint unsigned   n;
        longint unsigned   f;
        longint unsigned   u;
        longint unsigned   acc;
        longint unsigned   sh;
        int                i;
        for (i = 0; i <= EXP_DEPTH; i++) begin
            x   = (longint'(i) << 20) / EXP_DEPTH;
            y   = (x * 64'd94548 + 64'd32768) >> 16;
            n   = y >> 16;
            f   = y & 64'hFFFF;
            u   = (f * 64'd744261118) >> 16;
            // Sixth-order Horner series, terms 1/6 down to 1/1
            acc = 64'd1073741824;
            acc = 64'd1073741824 - (((u * acc) >> 30) / 64'd6);
            acc = 64'd1073741824 - (((u * acc) >> 30) / 64'd5);
            acc = 64'd1073741824 - (((u * acc) >> 30) >> 2);
            acc = 64'd1073741824 - (((u * acc) >> 30) / 64'd3);
            acc = 64'd1073741824 - (((u * acc) >> 30) >> 1);
            acc = 64'd1073741824 - ((u * acc) >> 30);
            if (n > 40) begin
                tab[i] = '0;
            end else begin
                sh     = 14 + n;
                tab[i] = WGT_W'((acc + (64'd1 << (sh - 1))) >> sh);
            end
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = build_exp_tab();

endpackage

// ----- hdl/saos_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module saos_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hdl/saos_div.sv -----
// Restoring divider, one quotient bit per cycle.
module saos_div import saos_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [TOT_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);
    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [NUM_W-1:0]  r_num;
    logic [TOT_W-1:0]  r_rem;
    logic [TOT_W-1:0]  r_den;
    logic [TOT_W:0]    w_shift;
    logic              w_ge;

    // Trial subtract of the next partial remainder
    assign w_shift = {r_rem, r_num[NUM_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= w_ge ? TOT_W'(w_shift - {1'b0, r_den}) : TOT_W'(w_shift);
                r_num <= {r_num[NUM_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CW'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;
endmodule

// ----- hdl/saos_front.sv -----
// Front end: takes requests, classifies them and queues them for the back end.
module saos_front import saos_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [6:0]  i_dim_index,
    input  logic [15:0] i_query_value,
    input  logic [12:0] i_key_index,
    input  logic        i_from_buffer,
    input  logic        i_key_invalid,
    input  logic [15:0] i_key_element,
    input  logic [15:0] i_value_element,
    input  logic        i_last_dim,
    output t_req        o_req,
    output logic        o_req_valid,
    input  logic        i_pop
);
    t_req            r_fifo [Q_DEPTH];
    logic [QA_W-1:0] r_wr_ptr;
    logic [QA_W-1:0] r_rd_ptr;
    logic [QA_W:0]   r_count;
    logic [QA_W:0]   n_count;
    logic            w_push;
    t_req            w_req;

    // Classify the incoming request
    always_comb begin
        w_req.op            = t_op'(i_operation);
        w_req.dim           = i_dim_index;
        w_req.dim_ok        = (int'(i_dim_index) < VEC_DIM);
        w_req.query_value   = i_query_value;
        w_req.key_index     = i_key_index;
        w_req.slot_ok       = !i_key_index[12] && (int'(i_key_index[11:0]) < KEY_SLOTS);
        w_req.from_buffer   = i_from_buffer;
        w_req.key_invalid   = i_key_invalid;
        w_req.key_element   = i_key_element;
        w_req.value_element = i_value_element;
        w_req.last_dim      = i_last_dim;
    end

    assign o_in_stall  = (r_count == (QA_W+1)'(Q_DEPTH));
    assign w_push      = i_in_valid && !o_in_stall;
    assign o_req_valid = (r_count != '0);
    assign o_req       = r_fifo[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (w_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wr_ptr] <= w_req;
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end
endmodule

// ----- hdl/saos_back.sv -----
// Back end: sequencer for dot products, online softmax update, reads and clearing.
module saos_back import saos_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_req        i_req,
    input  logic        i_req_valid,
    output logic        o_pop,
    input  logic [15:0] i_score_scale,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [6:0]  o_out_dim,
    output logic [15:0] o_out_value
);
    localparam logic signed [59:0] SUM60_MAX = 60'sh7FFFFFFFFF;
    localparam logic signed [59:0] SUM60_MIN = -60'sh8000000000;

    t_bstate            r_state;
    t_bstate            n_state;
    t_req               r_req;
    logic [DOT_W-1:0]   r_dot;
    logic [31:0]        r_max;
    logic [TOT_W-1:0]   r_total;
    logic [SW_W-1:0]    r_cnt;
    logic [VEC_AW-1:0]  r_idx;
    logic               r_neg;
    logic [63:0]        r_prod;
    logic [31:0]        r_score;
    logic               r_new;
    logic               r_inr;
    logic [EXP_AW-1:0]  r_tidx;
    logic [WGT_W-1:0]   r_wgt;
    logic signed [57:0] r_mp;
    logic [SUM_W-1:0]   r_base;
    logic [15:0]        r_res;
    logic               r_out_valid;
    logic [6:0]         r_out_dim;
    logic [15:0]        r_out_value;

    // RAM ports
    logic               w_q_we;
    logic [15:0]        w_q_rd;
    logic               w_vh_we;
    logic [15:0]        w_vh_rd;
    logic               w_ws_we;
    logic [VEC_AW-1:0]  w_ws_waddr;
    logic [SUM_W-1:0]   w_ws_wdata;
    logic [VEC_AW-1:0]  w_ws_raddr;
    logic [SUM_W-1:0]   w_ws_rd;
    logic               w_seen_we;
    logic [KS_AW-1:0]   w_seen_waddr;
    logic [KS_AW-1:0]   w_key_addr;
    logic [0:0]         w_seen_wdata;
    logic [0:0]         w_seen_rd;

    // Datapath nets
    logic               w_sweep_end;
    logic               w_out_free;
    logic signed [31:0] w_qk;
    logic [DOT_W-1:0]   w_dot_sum;
    logic [DOT_W-1:0]   w_dot_mag;
    logic [40:0]        w_m2;
    logic [31:0]        w_score;
    logic [33:0]        w_d;
    logic               w_new;
    logic [33:0]        w_x;
    logic               w_inr;
    logic [39:0]        w_ti;
    logic [39:0]        w_tic;
    logic [48:0]        w_tm;
    logic [33:0]        w_t;
    logic [SUM_W-1:0]   w_op;
    logic [SUM_W-1:0]   w_vh16;
    logic [57:0]        w_mmag;
    logic [57:0]        w_rmag;
    logic signed [59:0] w_rs;
    logic signed [59:0] w_sum;
    logic [SUM_W-1:0]   w_ws_new;
    logic [SUM_W-1:0]   w_rmag40;
    logic [NUM_W-1:0]   w_num;
    logic               w_div_start;
    logic               w_div_done;
    logic [NUM_W-1:0]   w_quo;
    logic [15:0]        w_qres;

    // Memories
    saos_ram #(.WIDTH(16), .DEPTH(VEC_DIM)) u_query (
        .i_clk(i_clk), .i_we(w_q_we), .i_waddr(VEC_AW'(i_req.dim)),
        .i_wdata(i_req.query_value), .i_raddr(VEC_AW'(i_req.dim)), .o_rdata(w_q_rd)
    );
    saos_ram #(.WIDTH(16), .DEPTH(VEC_DIM)) u_value (
        .i_clk(i_clk), .i_we(w_vh_we), .i_waddr(VEC_AW'(i_req.dim)),
        .i_wdata(i_req.value_element), .i_raddr(r_idx), .o_rdata(w_vh_rd)
    );
    saos_ram #(.WIDTH(SUM_W), .DEPTH(VEC_DIM)) u_wsum (
        .i_clk(i_clk), .i_we(w_ws_we), .i_waddr(w_ws_waddr),
        .i_wdata(w_ws_wdata), .i_raddr(w_ws_raddr), .o_rdata(w_ws_rd)
    );
    saos_ram #(.WIDTH(1), .DEPTH(KEY_SLOTS)) u_seen (
        .i_clk(i_clk), .i_we(w_seen_we), .i_waddr(w_seen_waddr),
        .i_wdata(w_seen_wdata), .i_raddr(w_key_addr), .o_rdata(w_seen_rd)
    );

    saos_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(w_num), .i_den(r_total), .o_done(w_div_done), .o_quo(w_quo)
    );

    assign w_key_addr  = KS_AW'($unsigned(r_req.key_index));
    assign w_sweep_end = (r_cnt == SW_W'(SWEEP_N - 1));
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // Key element: query times key, accumulated modulo 2^48
    assign w_qk      = $signed(w_q_rd) * $signed(r_req.key_element);
    assign w_dot_sum = r_req.dim_ok ? (r_dot + {{16{w_qk[31]}}, w_qk}) : r_dot;

    // Score: |dot| * scale, rounded and saturated to signed Q16.16
    assign w_dot_mag = r_dot[DOT_W-1] ? (~r_dot + 1'b1) : r_dot;
    assign w_m2      = 41'((r_prod + 64'd8388608) >> 24);
    always_comb begin
        if (r_neg) begin
            w_score = (w_m2 > 41'd2147483648) ? 32'h80000000 : (32'd0 - w_m2[31:0]);
        end else begin
            w_score = (w_m2 > 41'd2147483647) ? 32'h7FFFFFFF : w_m2[31:0];
        end
    end

    // Difference to running max and table index
    assign w_d     = {{2{r_score[31]}}, r_score} - {{2{r_max[31]}}, r_max};
    assign w_new   = !w_d[33] && (w_d != '0);
    assign w_x     = w_d[33] ? (34'd0 - w_d) : w_d;
    assign w_inr   = w_new ? (w_x < 34'h100000) : (w_x <= 34'h100000);
    assign w_ti    = (40'(w_x[20:0]) * 40'(EXP_DEPTH) + 40'h80000) >> 20;
    assign w_tic   = (w_ti > 40'(EXP_DEPTH)) ? 40'(EXP_DEPTH) : w_ti;

    // Total update
    assign w_tm = 49'(r_total) * 49'(r_wgt);
    assign w_t  = r_new ? (34'((w_tm + 49'd32768) >> 16) + 34'd65536)
                        : (34'(r_total) + 34'(r_wgt));

    // Per-entry weighted sum update
    assign w_vh16 = {{(SUM_W-20){w_vh_rd[15]}}, w_vh_rd, 4'd0};
    assign w_op   = r_new ? w_ws_rd : {{(SUM_W-16){w_vh_rd[15]}}, w_vh_rd};
    assign w_mmag = r_mp[57] ? 58'(-r_mp) : 58'(r_mp);
    assign w_rmag = r_new ? ((w_mmag + 58'd32768) >> 16) : ((w_mmag + 58'd2048) >> 12);
    assign w_rs   = r_mp[57] ? -$signed({2'b00, w_rmag}) : $signed({2'b00, w_rmag});
    assign w_sum  = w_rs + $signed({{20{r_base[SUM_W-1]}}, r_base});
    always_comb begin
        if (w_sum > SUM60_MAX) begin
            w_ws_new = SUM60_MAX[SUM_W-1:0];
        end else if (w_sum < SUM60_MIN) begin
            w_ws_new = SUM60_MIN[SUM_W-1:0];
        end else begin
            w_ws_new = w_sum[SUM_W-1:0];
        end
    end

    // Read: (|sum| << 12 + total/2) / total, then sign and saturate
    assign w_rmag40 = w_ws_rd[SUM_W-1] ? (~w_ws_rd + 1'b1) : w_ws_rd;
    assign w_num    = {w_rmag40, 12'd0} + NUM_W'(r_total >> 1);
    always_comb begin
        if (r_neg) begin
            w_qres = (w_quo > NUM_W'(32768)) ? 16'h8000 : (16'd0 - w_quo[15:0]);
        end else begin
            w_qres = (w_quo > NUM_W'(32767)) ? 16'h7FFF : w_quo[15:0];
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and memory strobes
    always_comb begin
        n_state      = r_state;
        o_pop        = 1'b0;
        w_q_we       = 1'b0;
        w_vh_we      = 1'b0;
        w_ws_we      = 1'b0;
        w_ws_waddr   = r_idx;
        w_ws_wdata   = w_ws_new;
        w_ws_raddr   = r_idx;
        w_seen_we    = 1'b0;
        w_seen_waddr = w_key_addr;
        w_seen_wdata = 1'b1;
        w_div_start  = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                w_ws_we      = (int'(r_cnt) < VEC_DIM);
                w_ws_waddr   = VEC_AW'(r_cnt);
                w_ws_wdata   = '0;
                w_seen_we    = (int'(r_cnt) < KEY_SLOTS);
                w_seen_waddr = KS_AW'(r_cnt);
                w_seen_wdata = 1'b0;
                if (w_sweep_end) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                w_ws_raddr = VEC_AW'(i_req.dim);
                if (i_req_valid) begin
                    o_pop = 1'b1;
                    unique case (i_req.op)
                        OP_LOAD: begin
                            w_q_we = i_req.dim_ok;
                        end
                        OP_START: begin
                            n_state = S_CLEAR;
                        end
                        OP_KEY: begin
                            w_vh_we = i_req.dim_ok;
                            n_state = S_KEY_MAC;
                        end
                        OP_READ: begin
                            if (!i_req.dim_ok || r_total == '0) begin
                                n_state = S_OUT;
                            end else begin
                                n_state = S_RD_WS;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_KEY_MAC: begin
                if (!r_req.last_dim) begin
                    n_state = S_IDLE;
                end else if (r_req.from_buffer) begin
                    n_state = S_MUL;
                end else if (!r_req.slot_ok) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SEEN;
                end
            end
            S_SEEN: begin
                w_seen_we = !w_seen_rd[0];
                if (w_seen_rd[0] || r_req.key_invalid) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL:   n_state = S_SCORE;
            S_SCORE: n_state = S_DIFF;
            S_DIFF: begin
                n_state = (!w_new && !w_inr) ? S_IDLE : S_EXP;
            end
            S_EXP:   n_state = S_TOT;
            S_TOT:   n_state = S_U_RD;
            S_U_RD:  n_state = S_U_MUL;
            S_U_MUL: n_state = S_U_WR;
            S_U_WR: begin
                w_ws_we = 1'b1;
                n_state = (r_idx == VEC_AW'(VEC_DIM - 1)) ? S_IDLE : S_U_RD;
            end
            S_RD_WS: begin
                w_div_start = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Softmax state and sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot   <= '0;
            r_max   <= 32'h80000000;
            r_total <= '0;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_cnt <= w_sweep_end ? '0 : r_cnt + 1'b1;
                end
                S_IDLE: begin
                    if (i_req_valid && i_req.op == OP_START) begin
                        r_dot   <= '0;
                        r_max   <= 32'h80000000;
                        r_total <= '0;
                    end
                end
                S_KEY_MAC: begin
                    if (r_req.last_dim && !r_req.from_buffer && !r_req.slot_ok) begin
                        r_dot <= '0;
                    end else begin
                        r_dot <= w_dot_sum;
                    end
                end
                S_SEEN: begin
                    if (w_seen_rd[0] || r_req.key_invalid) begin
                        r_dot <= '0;
                    end
                end
                S_MUL: r_dot <= '0;
                S_TOT: begin
                    r_total <= (w_t > 34'hFFFFFFFF) ? 32'hFFFFFFFF : w_t[31:0];
                    if (r_new) begin
                        r_max <= r_score;
                    end
                end
                default: ;
            endcase
        end
    end

    // Working registers of the update and read paths
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_req <= i_req;
                r_res <= '0;
            end
            S_MUL: begin
                r_neg  <= r_dot[DOT_W-1];
                r_prod <= 64'(w_dot_mag) * 64'(i_score_scale);
            end
            S_SCORE: r_score <= w_score;
            S_DIFF: begin
                r_new  <= w_new;
                r_inr  <= w_inr;
                r_tidx <= EXP_AW'(w_tic);
            end
            S_EXP: r_wgt <= (r_new && !r_inr) ? '0 : EXP_TAB[r_tidx];
            S_TOT: r_idx <= '0;
            S_U_MUL: begin
                r_mp   <= $signed(w_op) * $signed({1'b0, r_wgt});
                r_base <= r_new ? w_vh16 : w_ws_rd;
            end
            S_U_WR: r_idx <= r_idx + 1'b1;
            S_RD_WS: r_neg <= w_ws_rd[SUM_W-1];
            S_DIV: begin
                if (w_div_done) begin
                    r_res <= w_qres;
                end
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            r_out_dim   <= r_req.dim;
            r_out_value <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_dim   = r_out_dim;
    assign o_out_value = r_out_value;
endmodule

// ----- hdl/sparse_attention_online_softmax_core.sv -----
// Top level of the sparse attention online softmax core.
//
//  channel  direction  handshake                  payload
//  cfg      in         i_cfg_wr_en                i_cfg_wr_data (score_scale)
//  in       in         i_in_valid / o_in_stall    operation, dim, query, key flags, elements
//  out      out        o_out_valid / i_out_stall  out_dim, out_value
//
// Load: query memory write. Key element: query memory read, then multiply-accumulate.
// Key end: score, table lookup and total update, then the per-entry weighted sum pass over VEC_DIM entries.
// Read: a division by the total in the one-bit-per-cycle divider.
// Reset and start each run a clearing pass over the seen flags and weighted sums with no request taken.
// A four-entry queue lets requests arrive while the back end works.
module sparse_attention_online_softmax_core import saos_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [6:0]  i_dim_index,
    input  logic [15:0] i_query_value,
    input  logic [12:0] i_key_index,
    input  logic        i_from_buffer,
    input  logic        i_key_invalid,
    input  logic [15:0] i_key_element,
    input  logic [15:0] i_value_element,
    input  logic        i_last_dim,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [6:0]  o_out_dim,
    output logic [15:0] o_out_value
);
    logic [15:0] r_score_scale;
    t_req        w_req;
    logic        w_req_valid;
    logic        w_pop;

    // Scale register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score_scale <= SCALE_RST;
        end else if (i_cfg_wr_en) begin
            r_score_scale <= i_cfg_wr_data;
        end
    end

    saos_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_operation(i_operation), .i_dim_index(i_dim_index),
        .i_query_value(i_query_value), .i_key_index(i_key_index),
        .i_from_buffer(i_from_buffer), .i_key_invalid(i_key_invalid),
        .i_key_element(i_key_element), .i_value_element(i_value_element),
        .i_last_dim(i_last_dim),
        .o_req(w_req), .o_req_valid(w_req_valid), .i_pop(w_pop)
    );

    saos_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req(w_req), .i_req_valid(w_req_valid), .o_pop(w_pop),
        .i_score_scale(r_score_scale),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_out_dim(o_out_dim), .o_out_value(o_out_value)
    );

    // Back end never pops an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_req_valid)
        else $error("pop from empty request queue");

    // Clearing pass follows reset, so no request is taken right after it
    a_clear_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !w_pop)
        else $error("request taken during clearing pass");

    // Only a read request can lead to a new output request
    a_out_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_req.op != OP_READ) |=> !$rose(o_out_valid))
        else $error("output request without a read");
endmodule
